// ----- src/seeded_mersenne_lcg_stream_core_macros.svh -----
// Assertion macros for the checker file of the stream core.
`ifndef SEEDED_MERSENNE_LCG_STREAM_CORE_MACROS_SVH
`define SEEDED_MERSENNE_LCG_STREAM_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define SMLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define SMLS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/smls_pkg.sv -----
// Types and constants of the Mersenne 2^61-1 stream generator.
package smls_pkg;

  localparam int ID_W      = 32;
  localparam int COUNT_W   = 4;
  localparam int SEED_W    = 64;
  localparam int RESIDUE_W = 61;
  localparam int HALF_W    = 32;

  // Generator and hash multipliers
  localparam logic [SEED_W-1:0] LCG_MULT = 64'd437799614237992725;
  localparam logic [HALF_W-1:0] LCG_ML   = LCG_MULT[31:0];
  localparam logic [HALF_W-1:0] LCG_MH   = LCG_MULT[63:32];
  localparam logic [HALF_W-1:0] HASH_MULT = 32'd2654435761;

  // 2^61-1
  localparam logic [RESIDUE_W-1:0] MERSENNE61 = {RESIDUE_W{1'b1}};

  // Warm-up steps after a reseed
  localparam int WARM_W = 4;
  localparam logic [WARM_W-1:0] WARMUP_STEPS = 4'd10;

  // Item kinds
  localparam logic KIND_RESEED   = 1'b0;
  localparam logic KIND_CONTINUE = 1'b1;

  // Command queue between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    atom_id;
    logic [ID_W-1:0]    id_sum;
    logic [COUNT_W-1:0] count;
  } smls_cmd_t;

endpackage

// ----- src/smls_if.sv -----
// Valid/ready channel interfaces for input items and result residues.
interface smls_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [smls_pkg::ID_W-1:0]     atom_id;
  logic [smls_pkg::ID_W-1:0]     stream_sel;
  logic [smls_pkg::COUNT_W-1:0]  draw_count;

  modport source (output valid, output kind, output atom_id, output stream_sel,
                  output draw_count, input ready);
  modport sink   (input valid, input kind, input atom_id, input stream_sel,
                  input draw_count, output ready);
  modport monitor (input valid, input ready, input kind, input atom_id,
                   input stream_sel, input draw_count);
endinterface

interface smls_out_if;
  logic                           valid;
  logic                           ready;
  logic [smls_pkg::RESIDUE_W-1:0] residue;
  logic                           last;

  modport source  (output valid, output residue, output last, input ready);
  modport sink    (input valid, input residue, input last, output ready);
  modport monitor (input valid, input ready, input residue, input last);
endinterface

// ----- src/smls_front.sv -----
// Front end: accepts items, saturates the draw count, forms the hash sum.
module smls_front #(
  parameter int MAX_DRAWS = 8
) (
  smls_in_if.sink                items,
  output logic                   push_valid,
  output smls_pkg::smls_cmd_t    push_cmd,
  input  logic                   push_ready
);

  localparam int COUNT_MAX = (2 ** smls_pkg::COUNT_W) - 1;
  localparam logic [smls_pkg::COUNT_W-1:0] COUNT_CAP =
    smls_pkg::COUNT_W'((MAX_DRAWS > COUNT_MAX) ? COUNT_MAX : MAX_DRAWS);

  logic [smls_pkg::COUNT_W-1:0] count_sat;
  logic                         keep;

  // Clamp the requested count
  always_comb begin
    if (32'(items.draw_count) > MAX_DRAWS) begin
      count_sat = COUNT_CAP;
    end else begin
      count_sat = items.draw_count;
    end
  end

  // A continue item with no draws has no effect and is dropped here
  assign keep = (items.kind == smls_pkg::KIND_RESEED) || (count_sat != '0);

  assign items.ready = push_ready;
  assign push_valid  = items.valid && keep;

  always_comb begin
    push_cmd.kind    = items.kind;
    push_cmd.atom_id = items.atom_id;
    push_cmd.id_sum  = items.atom_id + items.stream_sel;
    push_cmd.count   = count_sat;
  end

endmodule

// ----- src/smls_queue.sv -----
// Short command queue between the front end and the generator engine.
module smls_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  smls_pkg::smls_cmd_t  push_cmd,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output smls_pkg::smls_cmd_t  pop_cmd
);

  smls_pkg::smls_cmd_t                entries [smls_pkg::QUEUE_DEPTH];
  logic [smls_pkg::QPTR_W-1:0]        wr_ptr;
  logic [smls_pkg::QPTR_W-1:0]        rd_ptr;
  logic [smls_pkg::QCNT_W-1:0]        fill;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (fill != smls_pkg::QCNT_W'(smls_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == smls_pkg::QPTR_W'(smls_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == smls_pkg::QPTR_W'(smls_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/smls_engine.sv -----
// Back end: seed hashing, warm-up and draws on one shared 32x32 multiplier.
module smls_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  smls_pkg::smls_cmd_t  cmd,
  smls_out_if.source           results
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_HASH_HI = 3'd1;
  localparam logic [2:0] S_HASH_LO = 3'd2;
  localparam logic [2:0] S_MUL_LL  = 3'd3;
  localparam logic [2:0] S_MUL_HL  = 3'd4;
  localparam logic [2:0] S_MUL_LH  = 3'd5;
  localparam logic [2:0] S_FOLD    = 3'd6;
  localparam logic [2:0] S_PUT     = 3'd7;

  logic [2:0]                       state;
  smls_pkg::smls_cmd_t              cur;
  logic [smls_pkg::SEED_W-1:0]      work;
  logic [smls_pkg::SEED_W-1:0]      acc;
  logic [smls_pkg::WARM_W-1:0]      warm;
  logic [smls_pkg::COUNT_W-1:0]     remain;

  logic [smls_pkg::HALF_W-1:0]      mul_a;
  logic [smls_pkg::HALF_W-1:0]      mul_b;
  logic [smls_pkg::SEED_W-1:0]      prod;
  logic [smls_pkg::RESIDUE_W:0]     fsum;
  logic [smls_pkg::RESIDUE_W:0]     fred;
  logic                             out_free;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !results.valid || results.ready;

  // Operand select for the shared multiplier
  always_comb begin
    case (state)
      S_HASH_HI: begin
        mul_a = cur.atom_id;
        mul_b = smls_pkg::HASH_MULT;
      end
      S_HASH_LO: begin
        mul_a = cur.id_sum;
        mul_b = smls_pkg::HASH_MULT;
      end
      S_MUL_LL: begin
        mul_a = work[31:0];
        mul_b = smls_pkg::LCG_ML;
      end
      S_MUL_HL: begin
        mul_a = work[63:32];
        mul_b = smls_pkg::LCG_ML;
      end
      S_MUL_LH: begin
        mul_a = work[31:0];
        mul_b = smls_pkg::LCG_MH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // Fold the 64-bit product modulo 2^61-1: the top three bits are added back as a 3-bit value
  assign fsum = {1'b0, acc[60:0]} + 62'(acc[63:61]);
  assign fred = (fsum >= {1'b0, smls_pkg::MERSENNE61}) ?
                fsum - {1'b0, smls_pkg::MERSENNE61} : fsum;

  // Sequencer and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      work   <= '0;
      warm   <= '0;
      remain <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            remain <= cmd.count;
            warm   <= '0;
            state  <= (cmd.kind == smls_pkg::KIND_RESEED) ? S_HASH_HI : S_MUL_LL;
          end
        end
        S_HASH_HI: begin
          work[63:32] <= prod[31:0];
          state       <= S_HASH_LO;
        end
        S_HASH_LO: begin
          work[31:0] <= prod[31:0];
          warm       <= smls_pkg::WARMUP_STEPS;
          state      <= S_MUL_LL;
        end
        S_MUL_LL: begin
          state <= S_MUL_HL;
        end
        S_MUL_HL: begin
          state <= S_MUL_LH;
        end
        S_MUL_LH: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          work <= {3'b000, fred[60:0]};
          if (warm != '0) begin
            warm <= warm - 1'b1;
            if (warm == 4'd1 && remain == '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_MUL_LL;
            end
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            remain <= remain - 1'b1;
            state  <= (remain == 4'd1) ? S_IDLE : S_MUL_LL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command and partial-product registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur <= cmd;
    end
    case (state)
      S_MUL_LL: acc <= prod;
      S_MUL_HL: acc[63:32] <= acc[63:32] + prod[31:0];
      S_MUL_LH: acc[63:32] <= acc[63:32] + prod[31:0];
      default:  acc <= acc;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_PUT && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      results.residue <= work[60:0];
      results.last    <= (remain == 4'd1);
    end
  end

endmodule

// ----- src/seeded_mersenne_lcg_stream_core.sv -----
// One generator step uses the shared 32x32 multiplier for three partial products, then
// does the mod 2^61-1 fold; each residue is then registered into the output.
// Reseed item: seed hash, ten warm-up steps, then n draws.
// Continue item: n draws that go on from the current generator state.
// Two commands wait ahead of the engine; input stalls only while both slots are taken.
// Synchronous reset clears the seed to zero, empties the queue and drops the output.
module seeded_mersenne_lcg_stream_core #(
  parameter int MAX_DRAWS = 8
) (
  input  logic       clk,
  input  logic       rst,
  smls_in_if.sink    items,
  smls_out_if.source results
);

  logic                 push_valid;
  logic                 push_ready;
  smls_pkg::smls_cmd_t  push_cmd;
  logic                 pop_valid;
  logic                 pop_ready;
  smls_pkg::smls_cmd_t  pop_cmd;

  smls_front #(
    .MAX_DRAWS (MAX_DRAWS)
  ) u_front (
    .items      (items),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  smls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  smls_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .results   (results)
  );

endmodule

// ----- src/smls_checker.sv -----
// Port-level checks of the stream core, bound to the top level.
`include "seeded_mersenne_lcg_stream_core_macros.svh"

module smls_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [smls_pkg::RESIDUE_W-1:0] out_residue,
  input logic                           out_last
);

  logic                         stall;
  logic                         at_modulus;
  logic [smls_pkg::RESIDUE_W:0] out_word;

  assign stall      = out_valid && !out_ready;
  assign at_modulus = (out_residue == smls_pkg::MERSENNE61);
  assign out_word   = {out_last, out_residue};

  // A stalled result holds its value
  `SMLS_ASSERT(a_out_hold, clk, rst, stall |=> out_valid && $stable(out_word), "result not held")

  // A residue is always reduced below 2^61-1
  `SMLS_ASSERT(a_residue_reduced, clk, rst, out_valid |-> !at_modulus, "residue not reduced")

  // Reset drops any pending result
  `SMLS_ASSERT_ALWAYS(a_reset_out, clk, rst |=> !out_valid, "result valid after reset")

  // Queue is empty after reset, so input is ready
  `SMLS_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> in_ready, "input not ready after reset")

endmodule

bind seeded_mersenne_lcg_stream_core smls_checker u_smls_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_residue (results.residue),
  .out_last    (results.last)
);
